[hdl/rtccal_pkg.sv]
package rtccal_pkg;

  localparam logic [1:0] CMD_TICK     = 2'd0;
  localparam logic [1:0] CMD_SET_TIME = 2'd1;
  localparam logic [1:0] CMD_SET_DATE = 2'd2;
  localparam logic [1:0] CMD_LOAD     = 2'd3;

  localparam logic [31:0] NTP_UNIX_OFFSET = 32'd2208988800;
  localparam logic [13:0] EPOCH_YEAR      = 14'd1970;
  localparam logic [13:0] YEAR_TOP        = 14'd9999;
  localparam logic [5:0]  DIV_MIN         = 6'd60;
  localparam logic [5:0]  DIV_HOUR        = 6'd24;
  localparam logic [5:0]  DIV_WEEK        = 6'd7;
  localparam logic [15:0] DAYS_YEAR       = 16'd365;
  localparam logic [15:0] DAYS_LEAP_YEAR  = 16'd366;
  // 1970 taken mod 4, 100 and 400
  localparam logic [1:0]  EPOCH_MOD4      = 2'd2;
  localparam logic [6:0]  EPOCH_MOD100    = 7'd70;
  localparam logic [8:0]  EPOCH_MOD400    = 9'd370;
  // 1970-01-01 was a Thursday
  localparam logic [15:0] EPOCH_WEEKDAY   = 16'd4;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_TICK,
    OP_SET_TIME,
    OP_SET_DATE,
    OP_LEAP,
    OP_EPOCH,
    OP_SAVE_SEC,
    OP_SAVE_MIN,
    OP_SAVE_HOUR,
    OP_SAVE_WDAY,
    OP_YEAR_STEP,
    OP_MONTH_STEP,
    OP_FINISH
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   capture;
    logic   out_load;
  } rtccal_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic year_done;
    logic month_done;
  } rtccal_stat_t;

  // y / 100 as (y * 5243) >> 19, exact below 43699
  function automatic logic is_leap(input logic [13:0] y);
    logic [26:0] prod;
    logic [7:0]  q;
    logic [13:0] r;
    prod = 27'(y) * 27'd5243;
    q    = prod[26:19];
    r    = y - ((14'(q) << 6) + (14'(q) << 5) + (14'(q) << 2));
    return ((y[1:0] == 2'd0) && (r != 14'd0)) || ((r == 14'd0) && (q[1:0] == 2'd0));
  endfunction

  function automatic logic [4:0] days_in(input logic [3:0] m, input logic leap);
    logic [4:0] d;
    if (m == 4'd2) begin
      d = leap ? 5'd29 : 5'd28;
    end else if (m inside {4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12}) begin
      d = 5'd31;
    end else begin
      d = 5'd30;
    end
    return d;
  endfunction

endpackage

[hdl/rtc_calendar_with_epoch_load_core.sv]
// path from accept to result: set time goes through its set state and the done state, tick and
// set date through their own state, the leap state and done; ntp load through four constant
// divisions by reciprocal multiply, a walk of one year per step from 1970, then one month per step
// one transaction in flight; the next is taken while the result waits in the output register
// synchronous active-low reset: calendar 2023-01-01 00:00:00 sunday, not running, zone 0
module rtc_calendar_with_epoch_load_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_cmd,
  input  logic [4:0]  in_set_hour,
  input  logic [5:0]  in_set_minute,
  input  logic [5:0]  in_set_second,
  input  logic [13:0] in_set_year,
  input  logic [3:0]  in_set_month,
  input  logic [4:0]  in_set_day,
  input  logic [31:0] in_ntp_seconds,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  out_cur_second,
  output logic [5:0]  out_cur_minute,
  output logic [4:0]  out_cur_hour,
  output logic [4:0]  out_cur_day,
  output logic [3:0]  out_cur_month,
  output logic [13:0] out_cur_year,
  output logic [2:0]  out_cur_weekday,
  output logic        out_cur_leap,
  output logic        out_running,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  rtccal_pkg::rtccal_cmd_t  cmd;
  rtccal_pkg::rtccal_stat_t st;
  logic [4:0] tz_r;

  // only the zone register exists, at addresses 0 to 3
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tz_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && !cfg_paddr[2]) begin
      tz_r <= cfg_pwdata[4:0];
    end
  end

  assign cfg_pready = 1'b1;
  assign cfg_prdata = cfg_paddr[2] ? 32'd0 : {27'd0, tz_r};

  rtccal_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_cmd    (in_cmd),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .st        (st)
  );

  rtccal_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .st              (st),
    .tz              (tz_r),
    .in_set_hour     (in_set_hour),
    .in_set_minute   (in_set_minute),
    .in_set_second   (in_set_second),
    .in_set_year     (in_set_year),
    .in_set_month    (in_set_month),
    .in_set_day      (in_set_day),
    .in_ntp_seconds  (in_ntp_seconds),
    .out_cur_second  (out_cur_second),
    .out_cur_minute  (out_cur_minute),
    .out_cur_hour    (out_cur_hour),
    .out_cur_day     (out_cur_day),
    .out_cur_month   (out_cur_month),
    .out_cur_year    (out_cur_year),
    .out_cur_weekday (out_cur_weekday),
    .out_cur_leap    (out_cur_leap),
    .out_running     (out_running)
  );

endmodule

[hdl/rtccal_div.sv]
module rtccal_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [5:0]  divisor,
  output logic        busy,
  output logic [31:0] quotient,
  output logic [5:0]  remainder
);

  // reciprocals of 15, 3 and 7 for the constant divisions
  localparam logic [31:0] RECIP_15 = 32'h88888889;
  localparam logic [31:0] RECIP_3  = 32'haaaaaaab;
  localparam logic [31:0] RECIP_7  = 32'd149797;

  logic        mul_r;
  logic        fix_r;
  logic [31:0] x_r;
  logic [5:0]  div_r;
  logic [63:0] prod_r;
  logic [31:0] quo_r;
  logic [5:0]  rem_r;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [31:0] q;
  logic [31:0] q_times_d;
  logic [31:0] diff;

  // x/60 = (x/4)/15 and x/24 = (x/8)/3; weekday dividends stay below 2^17
  always_comb begin
    case (div_r)
      rtccal_pkg::DIV_HOUR: begin
        mul_a = {3'd0, x_r[31:3]};
        mul_b = RECIP_3;
      end
      rtccal_pkg::DIV_WEEK: begin
        mul_a = {15'd0, x_r[16:0]};
        mul_b = RECIP_7;
      end
      default: begin
        mul_a = {2'd0, x_r[31:2]};
        mul_b = RECIP_15;
      end
    endcase
  end

  always_comb begin
    case (div_r)
      rtccal_pkg::DIV_HOUR: begin
        q         = {1'b0, prod_r[63:33]};
        q_times_d = (q << 4) + (q << 3);
      end
      rtccal_pkg::DIV_WEEK: begin
        q         = {17'd0, prod_r[34:20]};
        q_times_d = (q << 3) - q;
      end
      default: begin
        q         = {3'd0, prod_r[63:35]};
        q_times_d = (q << 6) - (q << 2);
      end
    endcase
    diff = x_r - q_times_d;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_r <= 1'b0;
      fix_r <= 1'b0;
    end else begin
      mul_r <= start;
      fix_r <= mul_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r   <= dividend;
      div_r <= divisor;
    end
    if (mul_r) begin
      prod_r <= 64'(mul_a) * 64'(mul_b);
    end
    if (fix_r) begin
      quo_r <= q;
      rem_r <= diff[5:0];
    end
  end

  assign busy      = mul_r | fix_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

[hdl/rtccal_dp.sv]
module rtccal_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rtccal_pkg::rtccal_cmd_t  cmd,
  output rtccal_pkg::rtccal_stat_t st,
  input  logic [4:0]           tz,
  input  logic [4:0]           in_set_hour,
  input  logic [5:0]           in_set_minute,
  input  logic [5:0]           in_set_second,
  input  logic [13:0]          in_set_year,
  input  logic [3:0]           in_set_month,
  input  logic [4:0]           in_set_day,
  input  logic [31:0]          in_ntp_seconds,
  output logic [5:0]           out_cur_second,
  output logic [5:0]           out_cur_minute,
  output logic [4:0]           out_cur_hour,
  output logic [4:0]           out_cur_day,
  output logic [3:0]           out_cur_month,
  output logic [13:0]          out_cur_year,
  output logic [2:0]           out_cur_weekday,
  output logic                 out_cur_leap,
  output logic                 out_running
);

  // captured transaction
  logic [4:0]  hour_in_r;
  logic [5:0]  min_in_r;
  logic [5:0]  sec_in_r;
  logic [13:0] year_in_r;
  logic [3:0]  mon_in_r;
  logic [4:0]  day_in_r;
  logic [31:0] ntp_r;

  // calendar state
  logic [5:0]  sec_r, sec_nxt;
  logic [5:0]  min_r, min_nxt;
  logic [4:0]  hour_r, hour_nxt;
  logic [4:0]  day_r, day_nxt;
  logic [3:0]  mon_r, mon_nxt;
  logic [13:0] year_r, year_nxt;
  logic [2:0]  wday_r, wday_nxt;
  logic        leap_r, leap_nxt;
  logic        valid_r, valid_nxt;

  // epoch walk
  logic [15:0] days_r, days_nxt;
  logic [1:0]  m4_r, m4_nxt;
  logic [6:0]  m100_r, m100_nxt;
  logic [8:0]  m400_r, m400_nxt;

  // output register
  logic [5:0]  o_sec_r, o_min_r;
  logic [4:0]  o_hour_r, o_day_r;
  logic [3:0]  o_mon_r;
  logic [13:0] o_year_r;
  logic [2:0]  o_wday_r;
  logic        o_leap_r, o_valid_r;

  logic        div_start;
  logic [31:0] div_dividend;
  logic [5:0]  div_divisor;
  logic        div_busy;
  logic [31:0] div_quo;
  logic [5:0]  div_rem;

  logic        walk_leap;
  logic [15:0] year_len;
  logic [4:0]  walk_dim;
  logic signed [16:0] tz_sec;
  logic [31:0] unix_t;

  logic [6:0]  s1, m1;
  logic [5:0]  h1, d1;
  logic [4:0]  mo1;

  rtccal_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .busy      (div_busy),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  assign walk_leap = ((m4_r == 2'd0) && (m100_r != 7'd0)) || (m400_r == 9'd0);
  assign year_len  = walk_leap ? rtccal_pkg::DAYS_LEAP_YEAR : rtccal_pkg::DAYS_YEAR;
  assign walk_dim  = rtccal_pkg::days_in(mon_r, walk_leap);

  assign st.div_busy   = div_busy;
  assign st.year_done  = (days_r < year_len);
  assign st.month_done = (mon_r == 4'd12) || (days_r < 16'(walk_dim));

  assign tz_sec = 17'($signed(tz)) * 17'sd3600;
  assign unix_t = ntp_r - rtccal_pkg::NTP_UNIX_OFFSET + 32'(tz_sec);

  always_comb begin
    div_start    = 1'b0;
    div_dividend = div_quo;
    div_divisor  = rtccal_pkg::DIV_MIN;
    case (cmd.op)
      rtccal_pkg::OP_EPOCH: begin
        div_start    = 1'b1;
        div_dividend = unix_t;
      end
      rtccal_pkg::OP_SAVE_SEC: begin
        div_start = 1'b1;
      end
      rtccal_pkg::OP_SAVE_MIN: begin
        div_start   = 1'b1;
        div_divisor = rtccal_pkg::DIV_HOUR;
      end
      rtccal_pkg::OP_SAVE_HOUR: begin
        div_start    = 1'b1;
        div_dividend = 32'(div_quo[15:0] + rtccal_pkg::EPOCH_WEEKDAY) ;
        div_divisor  = rtccal_pkg::DIV_WEEK;
        if (div_quo[15:0] > 16'hfffb) begin
          div_dividend = div_quo + 32'(rtccal_pkg::EPOCH_WEEKDAY);
        end
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  always_comb begin
    sec_nxt   = sec_r;
    min_nxt   = min_r;
    hour_nxt  = hour_r;
    day_nxt   = day_r;
    mon_nxt   = mon_r;
    year_nxt  = year_r;
    wday_nxt  = wday_r;
    leap_nxt  = leap_r;
    valid_nxt = valid_r;
    days_nxt  = days_r;
    m4_nxt    = m4_r;
    m100_nxt  = m100_r;
    m400_nxt  = m400_r;
    s1  = {1'b0, sec_r} + 7'd1;
    m1  = {1'b0, min_r} + 7'd1;
    h1  = {1'b0, hour_r} + 6'd1;
    d1  = {1'b0, day_r} + 6'd1;
    mo1 = {1'b0, mon_r} + 5'd1;
    case (cmd.op)
      rtccal_pkg::OP_TICK: begin
        if (valid_r) begin
          if (s1 < 7'd60) begin
            sec_nxt = s1[5:0];
          end else begin
            sec_nxt = '0;
            if (m1 < 7'd60) begin
              min_nxt = m1[5:0];
            end else begin
              min_nxt = '0;
              if (h1 < 6'd24) begin
                hour_nxt = h1[4:0];
              end else begin
                hour_nxt = '0;
                if (wday_r == 3'd6) begin
                  wday_nxt = 3'd0;
                end else if (wday_r == 3'd7) begin
                  wday_nxt = 3'd1;
                end else begin
                  wday_nxt = wday_r + 3'd1;
                end
                if (d1 > 6'(rtccal_pkg::days_in(mon_r, leap_r))) begin
                  day_nxt = 5'd1;
                  if (mo1 > 5'd12) begin
                    mon_nxt  = 4'd1;
                    year_nxt = (year_r >= rtccal_pkg::YEAR_TOP) ? 14'd0 : year_r + 14'd1;
                  end else begin
                    mon_nxt = mo1[3:0];
                  end
                end else begin
                  day_nxt = d1[4:0];
                end
              end
            end
          end
        end
      end
      rtccal_pkg::OP_SET_TIME: begin
        hour_nxt  = hour_in_r;
        min_nxt   = min_in_r;
        sec_nxt   = sec_in_r;
        valid_nxt = 1'b1;
      end
      rtccal_pkg::OP_SET_DATE: begin
        year_nxt  = year_in_r;
        mon_nxt   = mon_in_r;
        day_nxt   = day_in_r;
        valid_nxt = 1'b1;
      end
      rtccal_pkg::OP_LEAP: begin
        leap_nxt = rtccal_pkg::is_leap(year_r);
      end
      rtccal_pkg::OP_SAVE_SEC: begin
        sec_nxt = div_rem;
      end
      rtccal_pkg::OP_SAVE_MIN: begin
        min_nxt = div_rem;
      end
      rtccal_pkg::OP_SAVE_HOUR: begin
        hour_nxt = div_rem[4:0];
        days_nxt = div_quo[15:0];
      end
      rtccal_pkg::OP_SAVE_WDAY: begin
        wday_nxt = div_rem[2:0];
        year_nxt = rtccal_pkg::EPOCH_YEAR;
        mon_nxt  = 4'd1;
        m4_nxt   = rtccal_pkg::EPOCH_MOD4;
        m100_nxt = rtccal_pkg::EPOCH_MOD100;
        m400_nxt = rtccal_pkg::EPOCH_MOD400;
      end
      rtccal_pkg::OP_YEAR_STEP: begin
        days_nxt = days_r - year_len;
        year_nxt = year_r + 14'd1;
        m4_nxt   = m4_r + 2'd1;
        m100_nxt = (m100_r == 7'd99) ? 7'd0 : m100_r + 7'd1;
        m400_nxt = (m400_r == 9'd399) ? 9'd0 : m400_r + 9'd1;
      end
      rtccal_pkg::OP_MONTH_STEP: begin
        days_nxt = days_r - 16'(walk_dim);
        mon_nxt  = mon_r + 4'd1;
      end
      rtccal_pkg::OP_FINISH: begin
        day_nxt   = days_r[4:0] + 5'd1;
        leap_nxt  = walk_leap;
        valid_nxt = 1'b1;
      end
      default: begin
        valid_nxt = valid_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sec_r   <= '0;
      min_r   <= '0;
      hour_r  <= '0;
      day_r   <= 5'd1;
      mon_r   <= 4'd1;
      year_r  <= 14'd2023;
      wday_r  <= '0;
      leap_r  <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      sec_r   <= sec_nxt;
      min_r   <= min_nxt;
      hour_r  <= hour_nxt;
      day_r   <= day_nxt;
      mon_r   <= mon_nxt;
      year_r  <= year_nxt;
      wday_r  <= wday_nxt;
      leap_r  <= leap_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    days_r <= days_nxt;
    m4_r   <= m4_nxt;
    m100_r <= m100_nxt;
    m400_r <= m400_nxt;
    if (cmd.capture) begin
      hour_in_r <= in_set_hour;
      min_in_r  <= in_set_minute;
      sec_in_r  <= in_set_second;
      year_in_r <= in_set_year;
      mon_in_r  <= in_set_month;
      day_in_r  <= in_set_day;
      ntp_r     <= in_ntp_seconds;
    end
    if (cmd.out_load) begin
      o_sec_r   <= sec_r;
      o_min_r   <= min_r;
      o_hour_r  <= hour_r;
      o_day_r   <= day_r;
      o_mon_r   <= mon_r;
      o_year_r  <= year_r;
      o_wday_r  <= wday_r;
      o_leap_r  <= leap_r;
      o_valid_r <= valid_r;
    end
  end

  assign out_cur_second  = o_sec_r;
  assign out_cur_minute  = o_min_r;
  assign out_cur_hour    = o_hour_r;
  assign out_cur_day     = o_day_r;
  assign out_cur_month   = o_mon_r;
  assign out_cur_year    = o_year_r;
  assign out_cur_weekday = o_wday_r;
  assign out_cur_leap    = o_leap_r;
  assign out_running     = o_valid_r;

endmodule

[hdl/rtccal_ctrl.sv]
module rtccal_ctrl (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic [1:0]               in_cmd,
  output logic                     in_ready,
  output logic                     out_valid,
  input  logic                     out_ready,
  output rtccal_pkg::rtccal_cmd_t  cmd,
  input  rtccal_pkg::rtccal_stat_t st
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_TICK,
    S_SETT,
    S_SETD,
    S_LEAP,
    S_EPOCH,
    S_DSEC,
    S_DMIN,
    S_DHR,
    S_DWK,
    S_YEAR,
    S_MONTH,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt    = state_r;
    cmd.op       = rtccal_pkg::OP_NONE;
    cmd.capture  = 1'b0;
    cmd.out_load = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          case (in_cmd)
            rtccal_pkg::CMD_TICK:     state_nxt = S_TICK;
            rtccal_pkg::CMD_SET_TIME: state_nxt = S_SETT;
            rtccal_pkg::CMD_SET_DATE: state_nxt = S_SETD;
            default:                  state_nxt = S_EPOCH;
          endcase
        end
      end
      S_TICK: begin
        cmd.op    = rtccal_pkg::OP_TICK;
        state_nxt = S_LEAP;
      end
      S_SETT: begin
        cmd.op    = rtccal_pkg::OP_SET_TIME;
        state_nxt = S_DONE;
      end
      S_SETD: begin
        cmd.op    = rtccal_pkg::OP_SET_DATE;
        state_nxt = S_LEAP;
      end
      S_LEAP: begin
        cmd.op    = rtccal_pkg::OP_LEAP;
        state_nxt = S_DONE;
      end
      S_EPOCH: begin
        cmd.op    = rtccal_pkg::OP_EPOCH;
        state_nxt = S_DSEC;
      end
      S_DSEC: begin
        if (!st.div_busy) begin
          cmd.op    = rtccal_pkg::OP_SAVE_SEC;
          state_nxt = S_DMIN;
        end
      end
      S_DMIN: begin
        if (!st.div_busy) begin
          cmd.op    = rtccal_pkg::OP_SAVE_MIN;
          state_nxt = S_DHR;
        end
      end
      S_DHR: begin
        if (!st.div_busy) begin
          cmd.op    = rtccal_pkg::OP_SAVE_HOUR;
          state_nxt = S_DWK;
        end
      end
      S_DWK: begin
        if (!st.div_busy) begin
          cmd.op    = rtccal_pkg::OP_SAVE_WDAY;
          state_nxt = S_YEAR;
        end
      end
      S_YEAR: begin
        if (st.year_done) begin
          state_nxt = S_MONTH;
        end else begin
          cmd.op = rtccal_pkg::OP_YEAR_STEP;
        end
      end
      S_MONTH: begin
        if (st.month_done) begin
          cmd.op    = rtccal_pkg::OP_FINISH;
          state_nxt = S_DONE;
        end else begin
          cmd.op = rtccal_pkg::OP_MONTH_STEP;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

[hdl/rtccal_chk.sv]
module rtccal_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [13:0] out_cur_year,
  input logic [3:0]  out_cur_month,
  input logic [4:0]  out_cur_day,
  input logic [2:0]  out_cur_weekday,
  input logic        out_running
);

  // one transaction at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a transaction is in flight");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_cur_year))
    else $error("stalled result dropped or changed");

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // ticks before any set leave the reset calendar
  a_idle_calendar: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_running |->
      out_cur_year == 14'd2023 && out_cur_month == 4'd1 && out_cur_day == 5'd1)
    else $error("calendar moved before time was set");

  a_weekday_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_cur_weekday != 3'd7)
    else $error("weekday out of range");

endmodule

bind rtc_calendar_with_epoch_load_core rtccal_chk u_chk (.*);

[test/rtc_calendar_with_epoch_load_core_test.sv]
module rtc_calendar_with_epoch_load_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 3000000;
  localparam logic [2:0] REG_TZ_OFFSET = 3'd0;

  typedef struct packed {
    logic [5:0]  second;
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic [2:0]  weekday;
    logic        leap;
    logic        running;
  } calendar_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_cmd = rtccal_pkg::CMD_TICK;
  logic [4:0]  in_set_hour = '0;
  logic [5:0]  in_set_minute = '0;
  logic [5:0]  in_set_second = '0;
  logic [13:0] in_set_year = '0;
  logic [3:0]  in_set_month = '0;
  logic [4:0]  in_set_day = '0;
  logic [31:0] in_ntp_seconds = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [5:0]  out_cur_second;
  logic [5:0]  out_cur_minute;
  logic [4:0]  out_cur_hour;
  logic [4:0]  out_cur_day;
  logic [3:0]  out_cur_month;
  logic [13:0] out_cur_year;
  logic [2:0]  out_cur_weekday;
  logic        out_cur_leap;
  logic        out_running;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  rtc_calendar_with_epoch_load_core dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // model state
  logic [4:0]  zone_hours;
  logic [31:0] cal_sec, cal_min, cal_hour, cal_day, cal_month, cal_year, cal_wday;
  logic        cal_leap, cal_running;
  calendar_t   expected_dates[$];
  int          error_count = 0;
  int          cycle_count = 0;
  int          send_count = 0;

  function automatic logic leap_year(input logic [31:0] y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic logic [31:0] month_days(input logic [31:0] y, input logic [31:0] m);
    if (m == 2) return leap_year(y) ? 29 : 28;
    if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
    if (m >= 1 && m <= 12) return 31;
    return 30;
  endfunction

  task automatic reset_calendar();
    zone_hours = '0;
    cal_sec = 0; cal_min = 0; cal_hour = 0; cal_day = 1; cal_month = 1;
    cal_year = 2023; cal_wday = 0; cal_leap = 1'b0; cal_running = 1'b0;
  endtask

  task automatic advance_second();
    if (!cal_running) return;
    cal_sec++;
    if (cal_sec < 60) return;
    cal_sec = 0;
    cal_min++;
    if (cal_min < 60) return;
    cal_min = 0;
    cal_hour++;
    if (cal_hour < 24) return;
    cal_hour = 0;
    cal_day++;
    cal_wday = (cal_wday + 1) % 7;
    if (cal_day > month_days(cal_year, cal_month)) begin
      cal_day = 1;
      cal_month++;
      if (cal_month > 12) begin
        cal_month = 1;
        cal_year = (cal_year >= 9999) ? 0 : cal_year + 1;
        cal_leap = leap_year(cal_year);
      end
    end
  endtask

  task automatic convert_ntp(input logic [31:0] ntp);
    logic [31:0] t, total, days, y, m, len;
    t = ntp - 32'd2208988800;
    t = t + 32'($signed(zone_hours)) * 32'd3600;
    cal_sec = t % 60;
    cal_min = (t / 60) % 60;
    cal_hour = (t / 3600) % 24;
    total = t / 86400;
    days = total;
    y = 1970;
    forever begin
      len = leap_year(y) ? 366 : 365;
      if (days < len) break;
      days -= len;
      y++;
    end
    m = 1;
    while (m < 12 && days >= month_days(y, m)) begin
      days -= month_days(y, m);
      m++;
    end
    cal_year = y; cal_month = m; cal_day = days + 1;
    cal_wday = (total + 4) % 7;
    cal_leap = leap_year(y);
    cal_running = 1'b1;
  endtask

  task automatic predict_calendar(input logic [1:0] cmd, input logic [4:0] h,
                                  input logic [5:0] mi, input logic [5:0] s,
                                  input logic [13:0] y, input logic [3:0] mo,
                                  input logic [4:0] d, input logic [31:0] ntp);
    calendar_t c;
    case (cmd)
      rtccal_pkg::CMD_TICK: advance_second();
      rtccal_pkg::CMD_SET_TIME: begin
        cal_hour = 32'(h); cal_min = 32'(mi); cal_sec = 32'(s); cal_running = 1'b1;
      end
      rtccal_pkg::CMD_SET_DATE: begin
        cal_year = 32'(y); cal_month = 32'(mo); cal_day = 32'(d);
        cal_leap = leap_year(32'(y)); cal_running = 1'b1;
      end
      default: convert_ntp(ntp);
    endcase
    c.second = cal_sec[5:0]; c.minute = cal_min[5:0]; c.hour = cal_hour[4:0];
    c.day = cal_day[4:0]; c.month = cal_month[3:0]; c.year = cal_year[13:0];
    c.weekday = cal_wday[2:0]; c.leap = cal_leap; c.running = cal_running;
    expected_dates.push_back(c);
  endtask

  // valid stays high after an accept only when the next transaction follows at once
  task automatic send_command(input logic [1:0] cmd, input logic [4:0] h = '0,
                              input logic [5:0] mi = '0, input logic [5:0] s = '0,
                              input logic [13:0] y = '0, input logic [3:0] mo = '0,
                              input logic [4:0] d = '0, input logic [31:0] ntp = '0);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd; in_set_hour <= h; in_set_minute <= mi; in_set_second <= s;
    in_set_year <= y; in_set_month <= mo; in_set_day <= d; in_ntp_seconds <= ntp;
    do @(posedge clk); while (!in_ready);
    predict_calendar(cmd, h, mi, s, y, mo, d, ntp);
    send_count++;
  endtask

  task automatic write_zone(input logic [4:0] tz);
    in_valid <= 1'b0;
    while (expected_dates.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_paddr <= REG_TZ_OFFSET;
    cfg_pwdata <= {27'd0, tz};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    zone_hours = tz;
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
  endtask

  // result checker
  always @(posedge clk) begin
    calendar_t got, want;
    cycle_count <= cycle_count + 1;
    if (rst_n && out_valid && out_ready) begin
      got = {out_cur_second, out_cur_minute, out_cur_hour, out_cur_day, out_cur_month,
             out_cur_year, out_cur_weekday, out_cur_leap, out_running};
      if (expected_dates.size() == 0) begin
        $display("%0t unexpected transaction: actual %p", $time, got);
        error_count++;
      end else begin
        want = expected_dates.pop_front();
        if (got !== want) begin
          $display("%0t mismatch: expected %p actual %p", $time, want, got);
          error_count++;
        end
      end
    end
  end

  // receiver stalls
  initial begin
    int hold;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
        if (hold != 0) begin
          out_ready <= 1'b0;
          repeat (hold) @(posedge clk);
        end
        out_ready <= 1'b1;
      end else if (!out_ready) begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    @(posedge clk);
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("rtc_calendar_with_epoch_load_core regression: fail");
    $finish;
  end

  task automatic test_idle_ticks();
    send_command(rtccal_pkg::CMD_TICK);
    send_command(rtccal_pkg::CMD_TICK);
  endtask

  task automatic test_directed_rollovers();
    send_command(rtccal_pkg::CMD_SET_DATE, '0, '0, '0, 14'd9999, 4'd12, 5'd31);
    send_command(rtccal_pkg::CMD_SET_TIME, 5'd23, 6'd59, 6'd59);
    send_command(rtccal_pkg::CMD_TICK);
    send_command(rtccal_pkg::CMD_SET_DATE, '0, '0, '0, 14'd2024, 4'd2, 5'd28);
    send_command(rtccal_pkg::CMD_SET_TIME, 5'd23, 6'd59, 6'd59);
    send_command(rtccal_pkg::CMD_TICK);
    send_command(rtccal_pkg::CMD_SET_TIME, 5'd31, 6'd63, 6'd63);
    send_command(rtccal_pkg::CMD_TICK);
    send_command(rtccal_pkg::CMD_SET_DATE, '0, '0, '0, 14'h3fff, 4'd15, 5'd31);
    send_command(rtccal_pkg::CMD_SET_TIME, 5'd23, 6'd59, 6'd59);
    send_command(rtccal_pkg::CMD_TICK);
    send_command(rtccal_pkg::CMD_SET_DATE, '0, '0, '0, 14'd1900, 4'd0, 5'd0);
    send_command(rtccal_pkg::CMD_TICK);
    send_command(rtccal_pkg::CMD_LOAD, '0, '0, '0, '0, '0, '0, 32'd0);
    send_command(rtccal_pkg::CMD_LOAD, '0, '0, '0, '0, '0, '0, 32'hffffffff);
    send_command(rtccal_pkg::CMD_LOAD, '0, '0, '0, '0, '0, '0, 32'd2208988800);
    send_command(rtccal_pkg::CMD_LOAD, '0, '0, '0, '0, '0, '0, 32'd3913056000);
  endtask

  task automatic test_zone_extremes();
    logic [4:0] zones[5] = '{5'd14, 5'h14, 5'd15, 5'h10, 5'h1f};
    foreach (zones[i]) begin
      write_zone(zones[i]);
      send_command(rtccal_pkg::CMD_LOAD, '0, '0, '0, '0, '0, '0, 32'd2208988800);
      send_command(rtccal_pkg::CMD_LOAD, '0, '0, '0, '0, '0, '0, $urandom());
    end
  endtask

  task automatic test_random_mix(input int count);
    int pick;
    for (int i = 0; i < count; i++) begin
      if (i % 300 == 299) write_zone(5'($urandom()));
      pick = $urandom_range(0, 99);
      if (pick < 55) send_command(rtccal_pkg::CMD_TICK);
      else if (pick < 68)
        send_command(rtccal_pkg::CMD_SET_TIME, 5'($urandom_range(0, 23)),
                     6'($urandom_range(0, 59)),
                     ($urandom_range(0, 1) ? 6'd59 : 6'($urandom_range(0, 59))));
      else if (pick < 72)
        send_command(rtccal_pkg::CMD_SET_TIME, 5'($urandom()), 6'($urandom()),
                     6'($urandom()));
      else if (pick < 82)
        send_command(rtccal_pkg::CMD_SET_DATE, '0, '0, '0, 14'($urandom_range(0, 9999)),
                     4'($urandom_range(1, 12)), 5'($urandom_range(1, 31)));
      else if (pick < 85)
        send_command(rtccal_pkg::CMD_SET_DATE, '0, '0, '0, 14'($urandom()),
                     4'($urandom()), 5'($urandom()));
      else if (pick < 92)
        send_command(rtccal_pkg::CMD_LOAD, '0, '0, '0, '0, '0, '0, $urandom());
      else begin
        // park near midnight so the ticks reach the date carries
        send_command(rtccal_pkg::CMD_SET_TIME, 5'd23, 6'd59, 6'($urandom_range(55, 59)));
      end
    end
  endtask

  initial begin
    reset_calendar();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_idle_ticks();
    test_directed_rollovers();
    test_zone_extremes();
    write_zone(5'd0);
    test_random_mix(1750);
    in_valid <= 1'b0;
    while (expected_dates.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (error_count == 0) begin
      $display("rtc_calendar_with_epoch_load_core regression: pass");
    end else begin
      $display("rtc_calendar_with_epoch_load_core regression: fail");
    end
    $finish;
  end

endmodule

[files.f]
hdl/rtccal_pkg.sv
hdl/rtccal_div.sv
hdl/rtccal_dp.sv
hdl/rtccal_ctrl.sv
hdl/rtc_calendar_with_epoch_load_core.sv
hdl/rtccal_chk.sv
test/rtc_calendar_with_epoch_load_core_test.sv
